// ===== rtl/core/idwe_pkg.sv =====
// Package for the display write engine: command codes, bus phases,
// register indexes, protocol constants and the per-tick result record.
// No dependencies.
`default_nettype none

package idwe_pkg;

	// Request codes carried on the command field.
	typedef enum logic [1:0] {
		CMD_TICK      = 2'd0,
		CMD_SEND_CMD  = 2'd1,
		CMD_SEND_DATA = 2'd2,
		CMD_RESERVED  = 2'd3
	} cmd_t;

	// Bus phases of the write sequencer.
	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_STARTA = 4'd1,
		PH_STARTB = 4'd2,
		PH_SETUP  = 4'd3,
		PH_HIGH   = 4'd4,
		PH_LOW    = 4'd5,
		PH_ACK    = 4'd6,
		PH_STOPA  = 4'd7,
		PH_STOPB  = 4'd8
	} phase_t;

	// Configuration register indexes.
	typedef enum logic {
		CFG_HALF_PERIOD = 1'b0,
		CFG_DEVICE_ADDR = 1'b1
	} cfg_reg_t;

	localparam logic [15:0] HALF_PERIOD_RESET = 16'd40;
	localparam logic [7:0]  DEVICE_ADDR_RESET = 8'h78;
	localparam logic [7:0]  CTRL_CMD          = 8'h00;
	localparam logic [7:0]  CTRL_DATA         = 8'h40;
	localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;
	localparam logic [1:0]  LAST_BYTE_SLOT    = 2'd2;
	localparam logic [1:0]  CTRL_BYTE_SLOT    = 2'd1;

	// Line levels and status produced by one tick.
	typedef struct packed {
		logic scl;
		logic sda;
		logic busy;
		logic rejected;
		logic done;
	} result_t;

endpackage : idwe_pkg

`default_nettype wire

// ===== rtl/core/idwe_engine.sv =====
// Bus sequencer of the display write engine: holds the line and phase state
// and advances it by one tick per step. Depends on idwe_pkg.
`default_nettype none

module idwe_engine
	import idwe_pkg::*;
#(
	parameter int HOLD_COUNTER_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step_en,
	input  wire logic [1:0]  command,
	input  wire logic [7:0]  payload_byte,
	input  wire logic [15:0] half_period_ticks,
	input  wire logic [7:0]  device_address_byte,
	output result_t          result
);

	localparam int RW = (HOLD_COUNTER_BITS > 16) ? HOLD_COUNTER_BITS : 16;

	logic                         scl_q, scl_d;
	logic                         sda_q, sda_d;
	logic                         active_q, active_d;
	phase_t                       phase_q, phase_d;
	logic [3:0]                   bit_index_q, bit_index_d;
	logic [1:0]                   byte_slot_q, byte_slot_d;
	logic [7:0]                   shift_out_q, shift_out_d;
	logic [7:0]                   held_payload_q, held_payload_d;
	logic                         is_data_q, is_data_d;
	logic [HOLD_COUNTER_BITS-1:0] hold_count_q, hold_count_d;

	logic [15:0]                  reload_16;
	logic [RW-1:0]                reload_ext;
	logic [HOLD_COUNTER_BITS-1:0] reload;
	logic [3:0]                   bit_index_inc;
	logic                         req;
	cmd_t                         cmd;

	assign cmd = cmd_t'(command);
	assign req = (cmd == CMD_SEND_CMD) || (cmd == CMD_SEND_DATA);

	// A zero half period behaves as one; a reload too large for the counter saturates.
	assign reload_16  = (half_period_ticks == 16'd0) ? 16'd0 : half_period_ticks - 16'd1;
	assign reload_ext = RW'(reload_16);
	assign reload     = (reload_ext > RW'({HOLD_COUNTER_BITS{1'b1}})) ?
		{HOLD_COUNTER_BITS{1'b1}} : reload_ext[HOLD_COUNTER_BITS-1:0];

	assign bit_index_inc = bit_index_q + 4'd1;

	// Next state.
	always_comb begin
		scl_d          = scl_q;
		sda_d          = sda_q;
		active_d       = active_q;
		phase_d        = phase_q;
		bit_index_d    = bit_index_q;
		byte_slot_d    = byte_slot_q;
		shift_out_d    = shift_out_q;
		held_payload_d = held_payload_q;
		is_data_d      = is_data_q;
		hold_count_d   = hold_count_q;
		if (!active_q) begin
			if (req) begin
				active_d       = 1'b1;
				held_payload_d = payload_byte;
				is_data_d      = (cmd == CMD_SEND_DATA);
				byte_slot_d    = 2'd0;
				bit_index_d    = 4'd0;
				phase_d        = PH_STARTA;
				scl_d          = 1'b1;
				sda_d          = 1'b1;
				hold_count_d   = reload;
			end
		end else if (hold_count_q != '0) begin
			hold_count_d = hold_count_q - HOLD_COUNTER_BITS'(1);
		end else begin
			hold_count_d = reload;
			unique case (phase_q)
				PH_STARTA: begin
					phase_d = PH_STARTB;
					scl_d   = 1'b1;
					sda_d   = 1'b0;
				end
				PH_STARTB: begin
					byte_slot_d = 2'd0;
					bit_index_d = 4'd0;
					shift_out_d = device_address_byte;
					phase_d     = PH_SETUP;
					scl_d       = 1'b0;
					sda_d       = device_address_byte[7];
				end
				PH_SETUP: begin
					phase_d = PH_HIGH;
					scl_d   = 1'b1;
				end
				PH_HIGH: begin
					phase_d = PH_LOW;
					scl_d   = 1'b0;
				end
				PH_LOW: begin
					shift_out_d = {shift_out_q[6:0], 1'b0};
					bit_index_d = bit_index_inc;
					if (bit_index_inc >= BITS_PER_BYTE) begin
						phase_d = PH_ACK;
						scl_d   = 1'b1;
						sda_d   = 1'b1;
					end else begin
						phase_d = PH_SETUP;
						scl_d   = 1'b0;
						sda_d   = shift_out_q[6];
					end
				end
				PH_ACK: begin
					if (byte_slot_q < LAST_BYTE_SLOT) begin
						byte_slot_d = byte_slot_q + 2'd1;
						bit_index_d = 4'd0;
						if (byte_slot_q + 2'd1 == CTRL_BYTE_SLOT) begin
							shift_out_d = is_data_q ? CTRL_DATA : CTRL_CMD;
						end else begin
							shift_out_d = held_payload_q;
						end
						phase_d = PH_SETUP;
						scl_d   = 1'b0;
						sda_d   = shift_out_d[7];
					end else begin
						phase_d = PH_STOPA;
						scl_d   = 1'b0;
						sda_d   = 1'b0;
					end
				end
				PH_STOPA: begin
					phase_d = PH_STOPB;
					scl_d   = 1'b1;
					sda_d   = 1'b0;
				end
				default: begin
					// Stop B has run out, or the phase is stray: release both lines.
					scl_d        = 1'b1;
					sda_d        = 1'b1;
					active_d     = 1'b0;
					phase_d      = PH_IDLE;
					bit_index_d  = 4'd0;
					byte_slot_d  = 2'd0;
					hold_count_d = '0;
				end
			endcase
		end
	end

	// Outputs of the tick.
	always_comb begin
		result.scl      = scl_d;
		result.sda      = sda_d;
		result.busy     = active_d;
		result.rejected = active_q && req;
		result.done     = active_q && (hold_count_q == '0) &&
			(phase_q != PH_STARTA) && (phase_q != PH_STARTB) &&
			(phase_q != PH_SETUP) && (phase_q != PH_HIGH) &&
			(phase_q != PH_LOW) && (phase_q != PH_ACK) && (phase_q != PH_STOPA);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scl_q        <= 1'b1;
			sda_q        <= 1'b1;
			active_q     <= 1'b0;
			phase_q      <= PH_IDLE;
			bit_index_q  <= 4'd0;
			byte_slot_q  <= 2'd0;
			is_data_q    <= 1'b0;
			hold_count_q <= '0;
		end else if (step_en) begin
			scl_q        <= scl_d;
			sda_q        <= sda_d;
			active_q     <= active_d;
			phase_q      <= phase_d;
			bit_index_q  <= bit_index_d;
			byte_slot_q  <= byte_slot_d;
			is_data_q    <= is_data_d;
			hold_count_q <= hold_count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			shift_out_q    <= shift_out_d;
			held_payload_q <= held_payload_d;
		end
	end

endmodule : idwe_engine

`default_nettype wire

// ===== rtl/core/i2c_display_write_engine.sv =====
// Top level of the display write engine: input register, result register,
// configuration registers and the bus sequencer. Depends on idwe_pkg, idwe_engine.
`default_nettype none

// Bit-banged I2C master that writes one byte to a display controller. Every
// input transfer is one tick of bus time and yields exactly one result transfer
// carrying the SCL and SDA levels after that tick, a busy flag, a flag for a
// request dropped because a write was already running, and a done flag on the
// tick the stop condition completes. A command of one or two starts a write of
// three bytes (device address, control byte 0x00 for a command or 0x40 for data,
// then the payload), each MSB first with an extra clock on released SDA; no ACK
// is sampled. Each line level is held for half_period_ticks ticks. The block
// takes one input transfer per clock cycle while the output is not stalled:
// an item waits in the input register, then the sequencer state advances while
// the result is written into the output register. Throughput is one item per
// cycle, set by the single sequencer update per cycle, unless the result side
// stalls. A stall on the result side holds the output register and, one item
// later, the input side. Configuration writes are accepted in every cycle and
// must be made while the engine is idle with all results delivered.

module i2c_display_write_engine
	import idwe_pkg::*;
#(
	parameter int HOLD_COUNTER_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  command,
	input  wire logic [7:0]  payload_byte,
	// Result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             scl_level,
	output logic             sda_level,
	output logic             busy_res,
	output logic             rejected,
	output logic             done_res,
	// Configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data
);

	logic        valid_s1;
	logic [1:0]  command_s1;
	logic [7:0]  payload_s1;
	logic        valid_s2;
	result_t     result_s2;
	result_t     step_result;
	logic        advance;
	logic        in_take;
	logic [15:0] half_period_q;
	logic [7:0]  device_addr_q;

	// The item in the input register moves on whenever the result register is
	// empty or its transfer completes in this cycle.
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			command_s1 <= command;
			payload_s1 <= payload_byte;
		end
	end

	// The sequencer advances by exactly one tick per item leaving the input register.
	idwe_engine #(
		.HOLD_COUNTER_BITS(HOLD_COUNTER_BITS)
	) u_engine (
		.clk                (clk),
		.arst_n             (arst_n),
		.step_en            (advance),
		.command            (command_s1),
		.payload_byte       (payload_s1),
		.half_period_ticks  (half_period_q),
		.device_address_byte(device_addr_q),
		.result             (step_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= step_result;
		end
	end

	assign out_valid = valid_s2;
	assign scl_level = result_s2.scl;
	assign sda_level = result_s2.sda;
	assign busy_res  = result_s2.busy;
	assign rejected  = result_s2.rejected;
	assign done_res  = result_s2.done;

	// Configuration registers; a write transfer completes in any cycle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RESET;
			device_addr_q <= DEVICE_ADDR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_HALF_PERIOD: half_period_q <= cfg_data;
				CFG_DEVICE_ADDR: device_addr_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

endmodule : i2c_display_write_engine

`default_nettype wire

// ===== test/i2c_display_write_engine_tb.sv =====
// Self-checking testbench for the I2C display write engine: a directed table, then
// random bus traffic, every tick checked against a cycle-exact predictor of the lines.
// Depends on idwe_pkg and i2c_display_write_engine.
`default_nettype none

module i2c_display_write_engine_tb;
	import idwe_pkg::*;

	// Least number of random ticks to offer after the directed table; each random
	// phase also runs its last write to the end.
	localparam int RANDOM_TICKS = 600;

	// Kinds of rows in the directed table.
	typedef enum logic [1:0] {
		ROW_ITEM,
		ROW_SETTINGS,
		ROW_RUN_TO_DONE
	} row_kind_t;

	// One row of the directed table. For ROW_ITEM the line state is typed in only
	// where it is obvious; other rows take the predicted value. ROW_SETTINGS loads
	// both registers, and ROW_RUN_TO_DONE sends plain ticks until the next tick is
	// the one on which the stop condition completes.
	typedef struct {
		row_kind_t   kind;
		cmd_t        cmd;
		logic [7:0]  payload;
		logic [15:0] half;
		logic [15:0] addr;
		logic        typed;
		result_t     lines;
	} stim_row_t;

	// Clock, reset and every input of the block start at known values.
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	cmd_t        command = CMD_TICK;
	logic [7:0]  payload_byte = '0;
	logic        out_stall = 1'b0;
	logic        cfg_valid = 1'b0;
	cfg_reg_t    cfg_index = CFG_HALF_PERIOD;
	logic [15:0] cfg_data = '0;

	wire logic in_stall;
	wire logic out_valid;
	wire logic scl_level;
	wire logic sda_level;
	wire logic busy_res;
	wire logic rejected;
	wire logic done_res;
	wire logic cfg_ready;

	i2c_display_write_engine #(
		.HOLD_COUNTER_BITS(16)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.payload_byte(payload_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.scl_level(scl_level),
		.sda_level(sda_level),
		.busy_res(busy_res),
		.rejected(rejected),
		.done_res(done_res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor copy of the bus sequencer and its settings, at reset values.
	logic        bus_scl = 1'b1;
	logic        bus_sda = 1'b1;
	logic        bus_active = 1'b0;
	phase_t      bus_phase = PH_IDLE;
	logic [3:0]  bit_cnt = '0;
	logic [1:0]  byte_slot = '0;
	logic [7:0]  shreg = '0;
	logic [7:0]  held_byte = '0;
	logic        data_req = 1'b0;
	logic [15:0] hold_cnt = '0;
	logic [15:0] half_ticks = HALF_PERIOD_RESET;
	logic [7:0]  dev_addr = DEVICE_ADDR_RESET;

	// Line states still owed by the block, oldest first, and the bookkeeping.
	result_t pending_lines[$];
	int      line_errors = 0;
	int      ticks_sent = 0;
	int      lines_taken = 0;

	// A half period of zero counts as one; the hold counter is reloaded with one
	// less than the half period because the tick that changes the lines counts.
	function automatic logic [15:0] hold_reload();
		logic [15:0] h;
		h = (half_ticks == 16'd0) ? 16'd1 : half_ticks;
		return h - 16'd1;
	endfunction

	function automatic void enter_phase(input phase_t ph, input logic scl, input logic sda);
		bus_phase = ph;
		bus_scl = scl;
		bus_sda = sda;
		hold_cnt = hold_reload();
	endfunction

	// Advances the predicted sequencer by one tick and returns the lines after it.
	function automatic result_t advance_bus(input cmd_t c, input logic [7:0] p);
		result_t r;
		logic    req;
		r = '0;
		req = (c == CMD_SEND_CMD) || (c == CMD_SEND_DATA);
		if (!bus_active) begin
			if (req) begin
				bus_active = 1'b1;
				held_byte = p;
				data_req = (c == CMD_SEND_DATA);
				byte_slot = '0;
				bit_cnt = '0;
				enter_phase(PH_STARTA, 1'b1, 1'b1);
			end
		end else begin
			// A request while a write runs is dropped, but time still passes.
			r.rejected = req;
			if (hold_cnt != 16'd0) begin
				hold_cnt = hold_cnt - 16'd1;
			end else begin
				case (bus_phase)
					PH_STARTA: begin
						enter_phase(PH_STARTB, 1'b1, 1'b0);
					end
					PH_STARTB: begin
						byte_slot = '0;
						bit_cnt = '0;
						shreg = dev_addr;
						enter_phase(PH_SETUP, 1'b0, shreg[7]);
					end
					PH_SETUP: begin
						enter_phase(PH_HIGH, 1'b1, bus_sda);
					end
					PH_HIGH: begin
						enter_phase(PH_LOW, 1'b0, bus_sda);
					end
					PH_LOW: begin
						shreg = shreg << 1;
						bit_cnt = bit_cnt + 4'd1;
						if (bit_cnt >= BITS_PER_BYTE) begin
							enter_phase(PH_ACK, 1'b1, 1'b1);
						end else begin
							enter_phase(PH_SETUP, 1'b0, shreg[7]);
						end
					end
					PH_ACK: begin
						if (byte_slot < LAST_BYTE_SLOT) begin
							byte_slot = byte_slot + 2'd1;
							bit_cnt = '0;
							if (byte_slot == CTRL_BYTE_SLOT) begin
								shreg = data_req ? CTRL_DATA : CTRL_CMD;
							end else begin
								shreg = held_byte;
							end
							enter_phase(PH_SETUP, 1'b0, shreg[7]);
						end else begin
							enter_phase(PH_STOPA, 1'b0, 1'b0);
						end
					end
					PH_STOPA: begin
						enter_phase(PH_STOPB, 1'b1, 1'b0);
					end
					default: begin
						// Stop B has run out: SDA rises and the write is over.
						bus_scl = 1'b1;
						bus_sda = 1'b1;
						bus_active = 1'b0;
						bus_phase = PH_IDLE;
						bit_cnt = '0;
						byte_slot = '0;
						hold_cnt = '0;
						r.done = 1'b1;
					end
				endcase
			end
		end
		r.scl = bus_scl;
		r.sda = bus_sda;
		r.busy = bus_active;
		return r;
	endfunction

	task automatic flag_error(input string what);
		$display("ERROR at %0t: %s", $time, what);
		line_errors++;
	endtask

	// Offers one tick to the block after a random gap and, once the transfer
	// happens, records the line state it must produce.
	task automatic send_item(input cmd_t c, input logic [7:0] p, input logic typed,
			input result_t typed_lines);
		int      gap;
		result_t lines;
		// Every 200 ticks the sender runs flat out for 60 of them.
		gap = ((ticks_sent % 200) < 60) ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= c;
		payload_byte <= p;
		do @(posedge clk); while (in_stall);
		lines = advance_bus(c, p);
		pending_lines.push_back(typed ? typed_lines : lines);
		ticks_sent++;
	endtask

	// Loads both registers once every owed line state has come back. Callers make
	// sure the predicted sequencer is idle, so nothing is left in flight.
	task automatic load_settings(input logic [15:0] half, input logic [15:0] addr_word);
		in_valid <= 1'b0;
		while (pending_lines.size() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_HALF_PERIOD;
		cfg_data <= half;
		do @(posedge clk); while (!cfg_ready);
		half_ticks = half;
		cfg_index <= CFG_DEVICE_ADDR;
		cfg_data <= addr_word;
		do @(posedge clk); while (!cfg_ready);
		dev_addr = addr_word[7:0];
		cfg_valid <= 1'b0;
	endtask

	// Random traffic that follows the bus: when idle, mostly a new request; while a
	// write runs, mostly plain ticks with a few dropped requests and reserved codes.
	task automatic send_random_item();
		int         roll;
		logic [7:0] p;
		roll = $urandom_range(0, 99);
		p = 8'($urandom);
		if (!bus_active) begin
			if (roll < 70) begin
				send_item((roll < 35) ? CMD_SEND_CMD : CMD_SEND_DATA, p, 1'b0, '0);
			end else if (roll < 85) begin
				send_item(CMD_TICK, p, 1'b0, '0);
			end else begin
				send_item(CMD_RESERVED, p, 1'b0, '0);
			end
		end else begin
			if (roll < 88) begin
				send_item(CMD_TICK, p, 1'b0, '0);
			end else if (roll < 95) begin
				send_item((roll < 92) ? CMD_SEND_CMD : CMD_SEND_DATA, p, 1'b0, '0);
			end else begin
				send_item(CMD_RESERVED, p, 1'b0, '0);
			end
		end
	endtask

	// Directed table. It starts at the reset settings with an idle tick and a reserved
	// code, moves to a half period of three for a request and dropped requests, then
	// lands requests and ticks exactly on the done tick. Later rows use a zero half
	// period, the extreme addresses, both payload extremes and a new request right
	// after a write finishes.
	stim_row_t directed_rows [24] = '{
		'{ROW_ITEM,        CMD_TICK,      8'h00, 16'd0, 16'd0,    1'b1, 5'b11000},
		'{ROW_ITEM,        CMD_RESERVED,  8'hFF, 16'd0, 16'd0,    1'b1, 5'b11000},
		'{ROW_SETTINGS,    CMD_TICK,      8'h00, 16'd3, 16'h0078, 1'b0, 5'b00000},
		'{ROW_ITEM,        CMD_SEND_CMD,  8'hFF, 16'd0, 16'd0,    1'b1, 5'b11100},
		'{ROW_ITEM,        CMD_SEND_DATA, 8'h00, 16'd0, 16'd0,    1'b1, 5'b11110},
		'{ROW_ITEM,        CMD_RESERVED,  8'hAA, 16'd0, 16'd0,    1'b1, 5'b11100},
		'{ROW_RUN_TO_DONE, CMD_TICK,      8'h00, 16'd0, 16'd0,    1'b0, 5'b00000},
		'{ROW_ITEM,        CMD_SEND_CMD,  8'h55, 16'd0, 16'd0,    1'b1, 5'b11011},
		'{ROW_SETTINGS,    CMD_TICK,      8'h00, 16'd0, 16'h00FF, 1'b0, 5'b00000},
		'{ROW_ITEM,        CMD_SEND_DATA, 8'h00, 16'd0, 16'd0,    1'b0, 5'b00000},
		'{ROW_RUN_TO_DONE, CMD_TICK,      8'h00, 16'd0, 16'd0,    1'b0, 5'b00000},
		'{ROW_ITEM,        CMD_TICK,      8'h00, 16'd0, 16'd0,    1'b1, 5'b11001},
		'{ROW_SETTINGS,    CMD_TICK,      8'h00, 16'd2, 16'h0000, 1'b0, 5'b00000},
		'{ROW_ITEM,        CMD_SEND_CMD,  8'hA5, 16'd0, 16'd0,    1'b0, 5'b00000},
		'{ROW_RUN_TO_DONE, CMD_TICK,      8'h00, 16'd0, 16'd0,    1'b0, 5'b00000},
		'{ROW_ITEM,        CMD_RESERVED,  8'h00, 16'd0, 16'd0,    1'b1, 5'b11001},
		'{ROW_SETTINGS,    CMD_TICK,      8'h00, 16'd1, 16'h003C, 1'b0, 5'b00000},
		'{ROW_ITEM,        CMD_SEND_DATA, 8'hFF, 16'd0, 16'd0,    1'b0, 5'b00000},
		'{ROW_ITEM,        CMD_SEND_CMD,  8'h0F, 16'd0, 16'd0,    1'b0, 5'b00000},
		'{ROW_RUN_TO_DONE, CMD_TICK,      8'h00, 16'd0, 16'd0,    1'b0, 5'b00000},
		'{ROW_ITEM,        CMD_SEND_DATA, 8'h81, 16'd0, 16'd0,    1'b1, 5'b11011},
		'{ROW_ITEM,        CMD_SEND_CMD,  8'h7E, 16'd0, 16'd0,    1'b0, 5'b00000},
		'{ROW_RUN_TO_DONE, CMD_TICK,      8'h00, 16'd0, 16'd0,    1'b0, 5'b00000},
		'{ROW_ITEM,        CMD_TICK,      8'h00, 16'd0, 16'd0,    1'b1, 5'b11001}
	};

	// Sender: reset, the directed table, random phases, then the end of the run.
	initial begin
		int          random_base;
		int          chunk;
		logic [15:0] half;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			case (directed_rows[i].kind)
				ROW_ITEM: begin
					send_item(directed_rows[i].cmd, directed_rows[i].payload,
						directed_rows[i].typed, directed_rows[i].lines);
				end
				ROW_SETTINGS: begin
					load_settings(directed_rows[i].half, directed_rows[i].addr);
				end
				default: begin
					while (bus_active && !(hold_cnt == 16'd0 && bus_phase == PH_STOPB))
						send_item(CMD_TICK, 8'($urandom), 1'b0, '0);
				end
			endcase
		end

		// Random phases. Most use short half periods so that many complete writes
		// fit in the run; a few stretch the bit timing further. Each phase runs the
		// bus back to idle before the registers change.
		random_base = ticks_sent;
		while (ticks_sent - random_base < RANDOM_TICKS) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: half = 16'($urandom_range(1, 3));
				6, 7:             half = 16'($urandom_range(4, 8));
				8:                half = 16'd0;
				default:          half = 16'($urandom_range(9, 16));
			endcase
			load_settings(half, 16'($urandom));
			chunk = $urandom_range(100, 250);
			repeat (chunk) send_random_item();
			while (bus_active) send_item(CMD_TICK, 8'($urandom), 1'b0, '0);
		end

		// The largest half period: a write starts and the run ends long before its
		// first level change, so only the hold and the dropped requests are seen.
		load_settings(16'hFFFF, 16'($urandom));
		send_item(CMD_SEND_DATA, 8'($urandom), 1'b0, '0);
		repeat (40) send_random_item();

		in_valid <= 1'b0;
		while (pending_lines.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (line_errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Receiver: a random stall before each transfer, quiet stretches without any,
	// and one long hold-off so that the block fills up and stalls its input side.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (lines_taken == 700) begin
				n = 400;
			end else begin
				n = ((lines_taken % 170) < 50) ? 0 : $urandom_range(0, 15);
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
			lines_taken++;
		end
	end

	// Every result transfer is compared bit by bit with the oldest owed line state.
	task automatic check_lines(input result_t got);
		string   names [5] = '{"scl", "sda", "busy", "rejected", "done"};
		result_t want;
		if (pending_lines.size() == 0) begin
			flag_error($sformatf("result %b with no tick waiting for it", got));
		end else begin
			want = pending_lines.pop_front();
			for (int i = 0; i < 5; i++) begin
				if (got[4 - i] !== want[4 - i])
					flag_error($sformatf("%s got %b want %b", names[i], got[4 - i],
						want[4 - i]));
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_lines({scl_level, sda_level, busy_res, rejected, done_res});
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#10000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/idwe_pkg.sv
rtl/core/idwe_engine.sv
rtl/core/i2c_display_write_engine.sv
test/i2c_display_write_engine_tb.sv
